FILE: design/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle converter.
// No dependencies.
`default_nettype none

package qte_pkg;

    localparam int MW        = 35;   // rotation-matrix term width, Q28
    localparam int CW        = 38;   // CORDIC x/y datapath width
    localparam int AW        = 26;   // CORDIC angle, 2^-16 degree units
    localparam int SQ        = 29;   // result bits of the square root
    localparam int NW        = 57;   // square root radicand width
    localparam int TW        = 60;   // square root trial width
    localparam int OW        = 17;   // rounded angle before clamping
    localparam int MAX_STEPS = 24;

    localparam logic signed [MW-1:0] ONE_Q28 = 35'sd268435456;
    localparam logic signed [MW-1:0] LOCK_LO = 35'sd265751102;
    localparam logic signed [MW-1:0] LOCK_HI = 35'sd271119810;

    localparam logic signed [AW-1:0] DEG90 = 26'sd5898240;

    localparam logic signed [OW-1:0] LIM_X  = 17'sd11520;
    localparam logic signed [OW-1:0] LIM_YZ = 17'sd23040;

    // round(atan(2^-i)) in 2^-16 degree
    localparam logic signed [AW-1:0] ATAN_TAB [MAX_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    typedef logic signed [MW-1:0] mterm_t;
    typedef logic signed [CW-1:0] cw_t;
    typedef logic signed [AW-1:0] ang_t;

    typedef struct packed {
        logic pos;   // m21 near +1
        logic neg;   // m21 near -1
    } lock_t;

endpackage

`default_nettype wire

FILE: design/quaternion_to_euler_degrees_core.sv
// Throughput: one item per cycle; the pipeline advances as a whole and stalls only
// when its last stage holds a result and the two-entry output queue is full.
// Square root of 1 - v*v is a 29-stage restoring pipeline, one result bit a stage.
// Reset: asynchronous, active low; clears valid bits, queue pointers and queue count only.
`default_nettype none

module quaternion_to_euler_degrees_core
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    input  wire logic signed [15:0] quat_w,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [14:0]      angle_x,
    output logic signed [15:0]      angle_y,
    output logic signed [15:0]      angle_z
);

    localparam int NS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

    // ---------------- control ----------------
    logic          v1_reg, v2_reg, v3_reg, vo_reg;
    logic [SQ:0]   vs_reg;
    logic [NS:0]   vc_reg;
    logic [1:0]    cnt_reg;
    logic          wr_ptr_reg, rd_ptr_reg;
    logic          adv, push, pop;

    // ---------------- data ----------------
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    mterm_t m00_reg, m01_reg, m10_reg, m11_reg, m20_reg, m21_reg, m22_reg;

    lock_t              lk3_reg;
    logic signed [29:0] vq_reg;
    mterm_t             ly3_reg, lx3_reg, zy3_reg, zx3_reg;
    lock_t              lk3_next;
    logic signed [29:0] vq_next;
    mterm_t             vneg;
    logic signed [59:0] vsq;

    logic [NW-1:0]      rem_reg  [0:SQ];
    logic [SQ-1:0]      root_reg [0:SQ];
    logic [NW-1:0]      rem_next  [1:SQ];
    logic [SQ-1:0]      root_next [1:SQ];
    logic [TW-1:0]      trial     [0:SQ-1];
    lock_t              lks_reg [0:SQ];
    logic signed [29:0] vs_d_reg [0:SQ];
    mterm_t             lys_reg [0:SQ];
    mterm_t             lxs_reg [0:SQ];
    mterm_t             zys_reg [0:SQ];
    mterm_t             zxs_reg [0:SQ];

    cw_t    cx_reg [0:NS][0:2];
    cw_t    cy_reg [0:NS][0:2];
    ang_t   ca_reg [0:NS][0:2];
    logic [2:0] cz_reg  [0:NS];
    lock_t      clk_reg [0:NS];
    cw_t    cx_next [0:NS][0:2];
    cw_t    cy_next [0:NS][0:2];
    ang_t   ca_next [0:NS][0:2];
    cw_t    lane_y [0:2];
    cw_t    lane_x [0:2];
    cw_t    xs, ys;

    logic signed [14:0] ox_reg;
    logic signed [15:0] oy_reg, oz_reg;
    logic signed [14:0] ox_next;
    logic signed [15:0] oy_next, oz_next;
    logic signed [OW-1:0] rx, ry, rz;

    logic signed [14:0] qx_reg [0:1];
    logic signed [15:0] qy_reg [0:1];
    logic signed [15:0] qz_reg [0:1];

    function automatic logic signed [OW-1:0] to_deg(ang_t a, logic signed [OW-1:0] lim);
        ang_t                 s;
        logic signed [OW-1:0] r;
        s = a + ang_t'(256);
        r = OW'(s >>> 9);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    assign adv      = !(vo_reg && cnt_reg == 2'd2);
    assign in_ready = adv;
    assign push     = vo_reg && adv;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop      = out_valid && out_ready;
    assign angle_x  = qx_reg[rd_ptr_reg];
    assign angle_y  = qy_reg[rd_ptr_reg];
    assign angle_z  = qz_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            vs_reg     <= '0;
            vc_reg     <= '0;
            vo_reg     <= 1'b0;
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg <= in_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                vs_reg <= {vs_reg[SQ-1:0], v3_reg};
                vc_reg <= {vc_reg[NS-1:0], vs_reg[SQ]};
                vo_reg <= vc_reg[NS];
            end
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // lock detect, asin argument saturation, square of the saturated argument
    always_comb
    begin
        lk3_next.pos = (m21_reg >= LOCK_LO) && (m21_reg <= LOCK_HI);
        lk3_next.neg = (m21_reg >= -LOCK_HI) && (m21_reg <= -LOCK_LO);
        vneg = -m21_reg;
        if (vneg > ONE_Q28)
            vq_next = 30'(ONE_Q28);
        else if (vneg < -ONE_Q28)
            vq_next = 30'(-ONE_Q28);
        else
            vq_next = 30'(vneg);
        vsq = vq_reg * vq_reg;
    end

    // restoring square root, bit SQ-1-k decided in stage k
    always_comb
    begin
        for (int k = 0; k < SQ; k++)
        begin
            trial[k] = ({{(TW-SQ){1'b0}}, root_reg[k]} << (SQ - k))
                     + (TW'(1) << (2 * (SQ - 1 - k)));
            if ({{(TW-NW){1'b0}}, rem_reg[k]} >= trial[k])
            begin
                rem_next[k+1]  = rem_reg[k] - trial[k][NW-1:0];
                root_next[k+1] = root_reg[k] | (SQ'(1) << (SQ - 1 - k));
            end
            else
            begin
                rem_next[k+1]  = rem_reg[k];
                root_next[k+1] = root_reg[k];
            end
        end
    end

    // CORDIC: quadrant fold then vectoring iterations, three lanes side by side
    always_comb
    begin
        lane_y[0] = CW'(vs_d_reg[SQ]);
        lane_x[0] = CW'($signed({1'b0, root_reg[SQ]}));
        lane_y[1] = CW'(lys_reg[SQ]);
        lane_x[1] = CW'(lxs_reg[SQ]);
        lane_y[2] = CW'(zys_reg[SQ]);
        lane_x[2] = CW'(zxs_reg[SQ]);
        xs = '0;
        ys = '0;
        for (int l = 0; l < 3; l++)
        begin
            if (lane_x[l] < 0)
            begin
                if (lane_y[l] >= 0)
                begin
                    cx_next[0][l] = lane_y[l];
                    cy_next[0][l] = -lane_x[l];
                    ca_next[0][l] = DEG90;
                end
                else
                begin
                    cx_next[0][l] = -lane_y[l];
                    cy_next[0][l] = lane_x[l];
                    ca_next[0][l] = -DEG90;
                end
            end
            else
            begin
                cx_next[0][l] = lane_x[l];
                cy_next[0][l] = lane_y[l];
                ca_next[0][l] = '0;
            end
        end
        for (int i = 0; i < NS; i++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                xs = cx_reg[i][l] >>> i;
                ys = cy_reg[i][l] >>> i;
                if (cy_reg[i][l] > 0)
                begin
                    cx_next[i+1][l] = cx_reg[i][l] + ys;
                    cy_next[i+1][l] = cy_reg[i][l] - xs;
                    ca_next[i+1][l] = ca_reg[i][l] + ATAN_TAB[i];
                end
                else
                begin
                    cx_next[i+1][l] = cx_reg[i][l] - ys;
                    cy_next[i+1][l] = cy_reg[i][l] + xs;
                    ca_next[i+1][l] = ca_reg[i][l] - ATAN_TAB[i];
                end
            end
        end
    end

    // rounding, clamping, gimbal-lock override, zero-vector result
    always_comb
    begin
        rx = cz_reg[NS][0] ? '0 : to_deg(ca_reg[NS][0], LIM_X);
        ry = cz_reg[NS][1] ? '0 : to_deg(ca_reg[NS][1], LIM_YZ);
        rz = cz_reg[NS][2] ? '0 : to_deg(ca_reg[NS][2], LIM_YZ);
        if (clk_reg[NS].pos)
        begin
            ox_next = 15'(-LIM_X);
            oy_next = '0;
        end
        else if (clk_reg[NS].neg)
        begin
            ox_next = 15'(LIM_X);
            oy_next = '0;
        end
        else
        begin
            ox_next = 15'(rx);
            oy_next = 16'(ry);
        end
        oz_next = 16'(rz);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            xy_reg <= quat_x * quat_y;
            xz_reg <= quat_x * quat_z;
            yz_reg <= quat_y * quat_z;
            wx_reg <= quat_w * quat_x;
            wy_reg <= quat_w * quat_y;
            wz_reg <= quat_w * quat_z;

            m00_reg <= ONE_Q28 - (MW'(yy_reg) <<< 1) - (MW'(zz_reg) <<< 1);
            m01_reg <= (MW'(xy_reg) <<< 1) + (MW'(wz_reg) <<< 1);
            m10_reg <= (MW'(xy_reg) <<< 1) - (MW'(wz_reg) <<< 1);
            m11_reg <= ONE_Q28 - (MW'(xx_reg) <<< 1) - (MW'(zz_reg) <<< 1);
            m20_reg <= (MW'(xz_reg) <<< 1) + (MW'(wy_reg) <<< 1);
            m21_reg <= (MW'(yz_reg) <<< 1) - (MW'(wx_reg) <<< 1);
            m22_reg <= ONE_Q28 - (MW'(xx_reg) <<< 1) - (MW'(yy_reg) <<< 1);

            lk3_reg <= lk3_next;
            vq_reg  <= vq_next;
            ly3_reg <= m20_reg;
            lx3_reg <= m22_reg;
            if (lk3_next.pos || lk3_next.neg)
            begin
                zy3_reg <= m10_reg;
                zx3_reg <= m00_reg;
            end
            else
            begin
                zy3_reg <= m01_reg;
                zx3_reg <= m11_reg;
            end

            rem_reg[0]  <= (NW'(1) << (NW - 1)) - vsq[NW-1:0];
            root_reg[0] <= '0;
            lks_reg[0]  <= lk3_reg;
            vs_d_reg[0] <= vq_reg;
            lys_reg[0]  <= ly3_reg;
            lxs_reg[0]  <= lx3_reg;
            zys_reg[0]  <= zy3_reg;
            zxs_reg[0]  <= zx3_reg;
            for (int k = 1; k <= SQ; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                lks_reg[k]  <= lks_reg[k-1];
                vs_d_reg[k] <= vs_d_reg[k-1];
                lys_reg[k]  <= lys_reg[k-1];
                lxs_reg[k]  <= lxs_reg[k-1];
                zys_reg[k]  <= zys_reg[k-1];
                zxs_reg[k]  <= zxs_reg[k-1];
            end

            for (int i = 0; i <= NS; i++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    cx_reg[i][l] <= cx_next[i][l];
                    cy_reg[i][l] <= cy_next[i][l];
                    ca_reg[i][l] <= ca_next[i][l];
                end
            end
            cz_reg[0][0] <= (vs_d_reg[SQ] == '0) && (root_reg[SQ] == '0);
            cz_reg[0][1] <= (lys_reg[SQ] == '0) && (lxs_reg[SQ] == '0);
            cz_reg[0][2] <= (zys_reg[SQ] == '0) && (zxs_reg[SQ] == '0);
            clk_reg[0]   <= lks_reg[SQ];
            for (int i = 1; i <= NS; i++)
            begin
                cz_reg[i]  <= cz_reg[i-1];
                clk_reg[i] <= clk_reg[i-1];
            end

            ox_reg <= ox_next;
            oy_reg <= oy_next;
            oz_reg <= oz_next;
        end
        if (push)
        begin
            qx_reg[wr_ptr_reg] <= ox_reg;
            qy_reg[wr_ptr_reg] <= oy_reg;
            qz_reg[wr_ptr_reg] <= oz_reg;
        end
    end

    // ---------------- assertions ----------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");

    a_lock_excl: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> !(lk3_reg.pos && lk3_reg.neg))
        else $error("both gimbal-lock flags set");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vs_reg[SQ] |-> (root_reg[SQ] <= 29'd268435456))
        else $error("square root exceeds one");

    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        vo_reg |-> ((ox_reg <= 15'sd11520) && (ox_reg >= -15'sd11520)))
        else $error("x angle out of range");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for quaternion_to_euler_degrees_core: random and directed
// quaternions, a behavioural angle predictor, and a scoreboard of expected angles.
// Depends on qte_pkg and the core RTL.
`default_nettype none

module tb_top
    import qte_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS   = 16;
    localparam int LATENCY = STEPS + 35;

    typedef struct {
        logic signed [15:0] qx, qy, qz, qw;
    } quat_item_t;

    typedef struct {
        logic signed [14:0] ax;
        logic signed [15:0] ay, az;
    } euler_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [14:0] angle_x;
    logic signed [15:0] angle_y, angle_z;

    quat_item_t pending_quats[$];
    euler_t     expected_angles[$];
    int         mismatches = 0;
    bit         hold_sender = 1'b0;
    int         send_gap = 0;
    int         recv_gap = 0;

    quaternion_to_euler_degrees_core #(.CORDIC_STEPS(STEPS)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .out_valid(out_valid), .out_ready(out_ready),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // vectoring CORDIC, angle in 2^-16 degree
    function automatic longint vector_angle(longint y, longint x);
        longint acc;
        longint t;
        longint xs;
        longint ys;
        acc = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; acc = DEG90;
            end
            else
            begin
                t = x; x = -y; y = t; acc = -DEG90;
            end
        end
        for (int i = 0; i < STEPS && i < MAX_STEPS; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0)
            begin
                x += ys; y -= xs; acc += ATAN_TAB[i];
            end
            else
            begin
                x -= ys; y += xs; acc -= ATAN_TAB[i];
            end
        end
        return acc;
    endfunction

    function automatic longint round_clamp(longint a, longint lim);
        longint r;
        r = floor_shift(a + 256, 9);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic euler_t predict_euler(quat_item_t q);
        longint x, y, z, w, m00, m01, m10, m11, m20, m21, m22, v, c, one;
        euler_t e;
        x = q.qx; y = q.qy; z = q.qz; w = q.qw;
        one = ONE_Q28;
        m00 = one - 2*y*y - 2*z*z;
        m01 = 2*x*y + 2*w*z;
        m10 = 2*x*y - 2*w*z;
        m11 = one - 2*x*x - 2*z*z;
        m20 = 2*x*z + 2*w*y;
        m21 = 2*y*z - 2*w*x;
        m22 = one - 2*x*x - 2*y*y;
        if (m21 >= LOCK_LO && m21 <= LOCK_HI)
        begin
            e.ax = -15'sd11520;
            e.ay = '0;
            e.az = 16'(round_clamp(vector_angle(m10, m00), LIM_YZ));
        end
        else if (m21 >= -LOCK_HI && m21 <= -LOCK_LO)
        begin
            e.ax = 15'sd11520;
            e.ay = '0;
            e.az = 16'(round_clamp(vector_angle(m10, m00), LIM_YZ));
        end
        else
        begin
            v = -m21;
            if (v > one) v = one;
            if (v < -one) v = -one;
            c = int_sqrt(longint'(one*one - v*v));
            e.ax = 15'(round_clamp(vector_angle(v, c), LIM_X));
            e.ay = 16'(round_clamp(vector_angle(m20, m22), LIM_YZ));
            e.az = 16'(round_clamp(vector_angle(m01, m11), LIM_YZ));
        end
        return e;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // driver: presents items and out_ready at the falling edge, notes acceptances at the rising one
    bit sent_now = 1'b0;
    always @(posedge clk)
        sent_now <= in_valid && in_ready;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !sent_now)
                ;   // still waiting for acceptance
            else if (send_gap > 0 || hold_sender || pending_quats.size() == 0)
            begin
                in_valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                quat_x <= pending_quats[0].qx;
                quat_y <= pending_quats[0].qy;
                quat_z <= pending_quats[0].qz;
                quat_w <= pending_quats[0].qw;
                expected_angles.push_back(predict_euler(pending_quats[0]));
                void'(pending_quats.pop_front());
                in_valid <= 1'b1;
                if (!in_valid || sent_now)
                    send_gap <= pick_gap();
            end
            // a gap, if picked, starts after the item now presented
            if (recv_gap > 0)
            begin
                out_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        euler_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_angles.size() == 0)
            begin
                $error("unexpected result x=%0d y=%0d z=%0d", angle_x, angle_y, angle_z);
                mismatches++;
            end
            else
            begin
                e = expected_angles.pop_front();
                if (angle_x !== e.ax)
                begin
                    $error("angle_x expected %0d actual %0d", e.ax, angle_x);
                    mismatches++;
                end
                if (angle_y !== e.ay)
                begin
                    $error("angle_y expected %0d actual %0d", e.ay, angle_y);
                    mismatches++;
                end
                if (angle_z !== e.az)
                begin
                    $error("angle_z expected %0d actual %0d", e.az, angle_z);
                    mismatches++;
                end
            end
        end
    end

    function automatic quat_item_t mk(int x, int y, int z, int w);
        quat_item_t q;
        q.qx = 16'(x); q.qy = 16'(y); q.qz = 16'(z); q.qw = 16'(w);
        return q;
    endfunction

    function automatic int rnd_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16384;
        if (r == 1) return -16384;
        if (r == 2) return $signed(16'($urandom()));   // any 16-bit value, may be out of range
        return $urandom_range(0, 32768) - 16384;
    endfunction

    function automatic quat_item_t unit_quat();
        real a, b, c, d, n;
        quat_item_t q;
        a = $urandom_range(0, 2000) - 1000.0;
        b = $urandom_range(0, 2000) - 1000.0;
        c = $urandom_range(0, 2000) - 1000.0;
        d = $urandom_range(0, 2000) - 1000.0;
        n = $sqrt(a*a + b*b + c*c + d*d);
        if (n < 1.0)
            return mk(0, 0, 0, 16384);
        return mk(int'(a/n*16384.0), int'(b/n*16384.0), int'(c/n*16384.0),
                  int'(d/n*16384.0));
    endfunction

    // rotation about x near +/-90 degrees, so m21 sits by the lock bands
    function automatic quat_item_t near_lock();
        int dx;
        int s;
        dx = $urandom_range(0, 1400) - 700;
        s = $urandom_range(0, 1) ? 11585 : -11585;
        return mk(s + dx, $urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                  11585 - dx);
    endfunction

    initial
    begin
        int r;
        // directed: identity, axis extremes, both lock signs, zero, out-of-range
        pending_quats.push_back(mk(0, 0, 0, 16384));
        pending_quats.push_back(mk(0, 0, 0, -16384));
        pending_quats.push_back(mk(16384, 0, 0, 0));
        pending_quats.push_back(mk(0, 16384, 0, 0));
        pending_quats.push_back(mk(0, 0, 16384, 0));
        pending_quats.push_back(mk(-16384, 0, 0, 0));
        pending_quats.push_back(mk(11585, 0, 0, 11585));
        pending_quats.push_back(mk(-11585, 0, 0, 11585));
        pending_quats.push_back(mk(11585, 0, 0, 11585 - 300));
        pending_quats.push_back(mk(0, 11585, 11585, 0));
        pending_quats.push_back(mk(0, 0, 0, 0));
        pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
        pending_quats.push_back(mk(32767, 32767, 32767, 32767));
        pending_quats.push_back(mk(32767, -32768, 0, 0));
        pending_quats.push_back(mk(16384, 16384, 16384, 16384));
        pending_quats.push_back(mk(0, 0, 11585, 11585));
        pending_quats.push_back(mk(0, 11585, 0, -11585));
        pending_quats.push_back(mk(8192, 8192, 8192, 8192));
        pending_quats.push_back(mk(-16384, 16384, 16384, -16384));
        for (int i = 0; i < 600; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                pending_quats.push_back(unit_quat());
            else if (r < 7)
                pending_quats.push_back(near_lock());
            else
                pending_quats.push_back(mk(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp()));
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // hold the sender once the queue is half drained, until the pipe empties
        wait (pending_quats.size() < 300);
        @(negedge clk);
        hold_sender = 1'b1;
        wait (expected_angles.size() == 0 && !in_valid);
        @(negedge clk);
        hold_sender = 1'b0;
        wait (pending_quats.size() == 0);
        wait (!in_valid || sent_now);
        @(posedge clk);
        wait (expected_angles.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
